[hdl/pcov_pkg.sv]
// shared types and constants for the palette pixel and cursor overlay block
package pcov_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int CURSOR_MAX_SIDE_DEF = 64;
    localparam int MAX_LINE_WIDTH_DEF  = 1024;
    localparam int REPEAT_PERIOD_DEF   = 5;

    localparam int ROW_W      = 10;
    localparam int CFG_DATA_W = 11;

    typedef enum logic [1:0] {
        MODE_PIXEL      = 2'd0,
        MODE_GAME_PAL   = 2'd1,
        MODE_CURSOR_PAL = 2'd2,
        MODE_CURSOR_IMG = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CFG_SCREEN_WIDTH   = 3'd0,
        CFG_CURSOR_LEFT    = 3'd1,
        CFG_CURSOR_TOP     = 3'd2,
        CFG_CURSOR_WIDTH   = 3'd3,
        CFG_CURSOR_HEIGHT  = 3'd4,
        CFG_KEY_COLOR      = 3'd5,
        CFG_CURSOR_ENABLE  = 3'd6,
        CFG_CURSOR_PAL_SEL = 3'd7
    } cfg_index_t;

    typedef struct packed {
        mode_t       mode;
        logic        start_of_frame;
        logic [7:0]  pixel_index;
        logic [15:0] palette_color;
        logic [11:0] cursor_address;
        logic [7:0]  cursor_value;
    } in_item_t;

    typedef struct packed {
        logic [15:0] rgb_out;
        logic        end_of_line;
        logic        send_twice;
    } out_item_t;

endpackage

[hdl/palette_pixel_with_cursor_overlay.sv]
// palette lookup with cursor overlay: store loading, pixel pipeline and output skid
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+-------------------------------------
//  in       | in_valid, in_stall, in_data      | pixels and palette/image write requests
//  out      | out_valid, out_stall, out_data   | one composited pixel per pixel request
//  cfg      | cfg_we, cfg_index, cfg_data      | register writes, no read-back
//
// one request per cycle while in_stall is low; a taken pixel shows on out_valid
// after the image read, the palette read and the output register; the two
// registered memory reads lie in series
// reset clears counters, configuration registers and valid bits; the stores and payload are not cleared
// out_stall fills a one-entry skid, and in_stall rises while the skid is full
module palette_pixel_with_cursor_overlay
    import pcov_pkg::*;
#(
    parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF,
    parameter int CURSOR_MAX_SIDE = CURSOR_MAX_SIDE_DEF,
    parameter int MAX_LINE_WIDTH  = MAX_LINE_WIDTH_DEF,
    parameter int REPEAT_PERIOD   = REPEAT_PERIOD_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,

    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data,

    input  logic                  cfg_we,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PalW     = $clog2(PALETTE_ENTRIES);
    localparam int SideW    = $clog2(CURSOR_MAX_SIDE);
    localparam int ImgDepth = CURSOR_MAX_SIDE * CURSOR_MAX_SIDE;
    localparam int ImgW     = $clog2(ImgDepth);
    localparam int ProdW    = SideW + 7;
    localparam int ColW     = $clog2(MAX_LINE_WIDTH);
    localparam int CmpW     = (ColW + 1 > CFG_DATA_W) ? ColW + 1 : CFG_DATA_W;
    localparam int DW       = ((ColW > CFG_DATA_W) ? ColW : CFG_DATA_W) + 2;
    localparam int RmW      = $clog2(REPEAT_PERIOD);

    // configuration registers
    logic [10:0]        screen_width_reg;
    logic signed [10:0] cursor_left_reg;
    logic signed [10:0] cursor_top_reg;
    logic [6:0]         cursor_width_reg;
    logic [6:0]         cursor_height_reg;
    logic [7:0]         key_color_reg;
    logic               cursor_enable_reg;
    logic               cursor_pal_sel_reg;

    // counters
    logic [ColW-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [RmW-1:0]     rmod_reg, rmod_next;

    // stores
    logic [15:0]        gpal_mem [PALETTE_ENTRIES];
    logic [15:0]        cpal_mem [PALETTE_ENTRIES];
    logic [7:0]         img_mem  [ImgDepth];

    // pipeline
    logic               en;
    logic               accept;
    logic               pix_accept;
    logic               s1_valid_reg;
    logic               s1_hit_reg;
    logic               s1_eol_reg;
    logic               s1_send_reg;
    logic               s1_pix_ok_reg;
    logic [15:0]        gpal_rd0_reg;
    logic [7:0]         img_rd_reg;
    logic               s2_valid_reg;
    logic               s2_replace_reg;
    logic               s2_v_ok_reg;
    logic               s2_eol_reg;
    logic               s2_send_reg;
    logic [15:0]        s2_base_reg;
    logic [15:0]        gpal_rd1_reg;
    logic [15:0]        cpal_rd_reg;

    logic               out_valid_reg;
    out_item_t          out_reg;
    logic               skid_valid_reg;
    out_item_t          skid_reg;
    out_item_t          result;
    logic               take;

    // stage 0 signals
    logic [ColW-1:0]    col_cur;
    logic [ROW_W-1:0]   row_cur;
    logic [RmW-1:0]     rmod_cur;
    logic [CmpW-1:0]    sw_ext;
    logic [CmpW-1:0]    line_w;
    logic               eol;
    logic               send;
    logic [6:0]         cw;
    logic [6:0]         ch;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic               hit;
    logic [ProdW-1:0]   prod;
    logic [ImgW-1:0]    img_addr;
    logic [ImgW-1:0]    wr_img_addr;
    logic               img_wr_ok;
    logic [PalW-1:0]    pix_idx;
    logic               pix_ok;

    // stage 1 signals
    logic               replace;
    logic [PalW-1:0]    v_idx;
    logic               v_ok;

    assign en         = !skid_valid_reg;
    assign in_stall   = skid_valid_reg;
    assign accept     = in_valid && !in_stall;
    assign pix_accept = accept && (in_data.mode == MODE_PIXEL);
    assign take       = out_valid_reg && !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg   <= 11'd320;
            cursor_left_reg    <= '0;
            cursor_top_reg     <= '0;
            cursor_width_reg   <= '0;
            cursor_height_reg  <= '0;
            key_color_reg      <= '0;
            cursor_enable_reg  <= 1'b0;
            cursor_pal_sel_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:   screen_width_reg   <= cfg_data;
                CFG_CURSOR_LEFT:    cursor_left_reg    <= $signed(cfg_data);
                CFG_CURSOR_TOP:     cursor_top_reg     <= $signed(cfg_data);
                CFG_CURSOR_WIDTH:   cursor_width_reg   <= cfg_data[6:0];
                CFG_CURSOR_HEIGHT:  cursor_height_reg  <= cfg_data[6:0];
                CFG_KEY_COLOR:      key_color_reg      <= cfg_data[7:0];
                CFG_CURSOR_ENABLE:  cursor_enable_reg  <= cfg_data[0];
                CFG_CURSOR_PAL_SEL: cursor_pal_sel_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // stage 0: position, line end and cursor hit test
    always_comb
    begin
        col_cur  = in_data.start_of_frame ? '0 : col_reg;
        row_cur  = in_data.start_of_frame ? '0 : row_reg;
        rmod_cur = in_data.start_of_frame ? '0 : rmod_reg;

        // zero width acts as one, oversize clamps to the line buffer
        sw_ext = CmpW'(screen_width_reg);
        if (sw_ext == '0)
            line_w = CmpW'(1);
        else if (sw_ext > CmpW'(MAX_LINE_WIDTH))
            line_w = CmpW'(MAX_LINE_WIDTH);
        else
            line_w = sw_ext;

        eol  = (CmpW'(col_cur) + CmpW'(1)) >= line_w;
        send = (rmod_cur == '0);

        col_next  = col_reg;
        row_next  = row_reg;
        rmod_next = rmod_reg;
        if (pix_accept)
        begin
            if (eol)
            begin
                col_next = '0;
                row_next = row_cur + ROW_W'(1);
                // the row count wraps to zero, so the phase restarts with it
                if (row_cur == '1 || rmod_cur == RmW'(REPEAT_PERIOD - 1))
                    rmod_next = '0;
                else
                    rmod_next = rmod_cur + RmW'(1);
            end
            else
            begin
                col_next  = col_cur + ColW'(1);
                row_next  = row_cur;
                rmod_next = rmod_cur;
            end
        end

        cw = (32'(cursor_width_reg) > CURSOR_MAX_SIDE) ? 7'(CURSOR_MAX_SIDE)
                                                        : cursor_width_reg;
        ch = (32'(cursor_height_reg) > CURSOR_MAX_SIDE) ? 7'(CURSOR_MAX_SIDE)
                                                         : cursor_height_reg;

        dx = $signed(DW'(col_cur)) - DW'(cursor_left_reg);
        dy = $signed(DW'(row_cur)) - DW'(cursor_top_reg);

        hit = cursor_enable_reg
              && !dx[DW-1] && (dx < $signed(DW'(cw)))
              && !dy[DW-1] && (dy < $signed(DW'(ch)));

        // inside the rectangle the offset is always below the store depth
        prod     = ProdW'(dy[SideW-1:0]) * ProdW'(cw);
        img_addr = ImgW'(prod + ProdW'(dx[6:0]));

        wr_img_addr = ImgW'(in_data.cursor_address);
        img_wr_ok   = 32'(in_data.cursor_address) < ImgDepth;

        pix_idx = PalW'(in_data.pixel_index);
        pix_ok  = 32'(in_data.pixel_index) < PALETTE_ENTRIES;
    end

    // stage 1: key test on the image value
    assign replace = s1_hit_reg && (img_rd_reg != key_color_reg);
    assign v_idx   = PalW'(img_rd_reg);
    assign v_ok    = 32'(img_rd_reg) < PALETTE_ENTRIES;

    // store writes and registered reads
    always_ff @(posedge clk)
    begin
        if (accept && in_data.mode == MODE_GAME_PAL && pix_ok)
            gpal_mem[pix_idx] <= in_data.palette_color;
        if (en)
        begin
            gpal_rd0_reg <= gpal_mem[pix_idx];
            gpal_rd1_reg <= gpal_mem[v_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.mode == MODE_CURSOR_PAL && pix_ok)
            cpal_mem[pix_idx] <= in_data.palette_color;
        if (en)
            cpal_rd_reg <= cpal_mem[v_idx];
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.mode == MODE_CURSOR_IMG && img_wr_ok)
            img_mem[wr_img_addr] <= in_data.cursor_value;
        if (en)
            img_rd_reg <= img_mem[img_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            rmod_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            rmod_reg <= rmod_next;
            if (en)
            begin
                s1_valid_reg <= pix_accept;
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_hit_reg     <= hit;
            s1_eol_reg     <= eol;
            s1_send_reg    <= send;
            s1_pix_ok_reg  <= pix_ok;
            s2_replace_reg <= replace;
            s2_v_ok_reg    <= v_ok;
            s2_eol_reg     <= s1_eol_reg;
            s2_send_reg    <= s1_send_reg;
            s2_base_reg    <= s1_pix_ok_reg ? gpal_rd0_reg : 16'd0;
        end
    end

    // stage 2: final colour choice
    always_comb
    begin
        if (!s2_replace_reg)
            result.rgb_out = s2_base_reg;
        else if (!s2_v_ok_reg)
            result.rgb_out = 16'd0;
        else if (cursor_pal_sel_reg)
            result.rgb_out = cpal_rd_reg;
        else
            result.rgb_out = gpal_rd1_reg;
        result.end_of_line = s2_eol_reg;
        result.send_twice  = s2_send_reg;
    end

    // output register and skid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
                skid_valid_reg <= 1'b0;
        end
        else if (s2_valid_reg)
        begin
            if (out_valid_reg && !take)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
                out_reg <= skid_reg;
        end
        else if (s2_valid_reg)
        begin
            if (out_valid_reg && !take)
                skid_reg <= result;
            else
                out_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a pixel while the output register is empty");

    a_pixel_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.mode == MODE_PIXEL) |=> s1_valid_reg)
        else $error("accepted pixel request missing from first stage");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_data.mode != MODE_PIXEL) |=> !s1_valid_reg)
        else $error("store write request produced a pixel");

    a_skid_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !skid_valid_reg && out_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("pixel dropped while output is stalled");

endmodule

[tb/palette_pixel_with_cursor_overlay_tb.sv]
// self-checking testbench for the palette pixel and cursor overlay block
module palette_pixel_with_cursor_overlay_tb;
    import pcov_pkg::*;

    localparam int IMAGE_DEPTH   = CURSOR_MAX_SIDE_DEF * CURSOR_MAX_SIDE_DEF;
    localparam int REG_COUNT     = 8;
    localparam int HOLD_CYCLES   = 40;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 15;
    localparam int PHASE_ITEMS   = 34;
    localparam int HOLD_PHASE    = 8;
    localparam int USED_BAND     = 16;

    class overlay_scoreboard;
        logic [15:0]           game_pal [PALETTE_ENTRIES_DEF];
        logic [15:0]           cursor_pal [PALETTE_ENTRIES_DEF];
        logic [7:0]            cursor_img [IMAGE_DEPTH];
        bit                    img_written [IMAGE_DEPTH];
        logic [CFG_DATA_W-1:0] regs [REG_COUNT];
        int                    col;
        int                    row;
        out_item_t             pixels_due [$];
        int                    mismatches;

        function new();
            foreach (regs[i])
                regs[i] = '0;
            regs[CFG_SCREEN_WIDTH] = 11'd320;
            col = 0;
            row = 0;
            mismatches = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_CURSOR_WIDTH, CFG_CURSOR_HEIGHT: regs[idx] = {4'b0, data[6:0]};
                CFG_KEY_COLOR:                       regs[idx] = {3'b0, data[7:0]};
                CFG_CURSOR_ENABLE, CFG_CURSOR_PAL_SEL: regs[idx] = {10'b0, data[0]};
                default:                             regs[idx] = data;
            endcase
        endfunction

        // image offset the next pixel would read, or -1 when it is outside the cursor
        function int cursor_offset(bit sof);
            int x;
            int y;
            int cx;
            int cy;
            int cw;
            int ch;
            x = sof ? 0 : col;
            y = sof ? 0 : row;
            cx = int'($signed(regs[CFG_CURSOR_LEFT]));
            cy = int'($signed(regs[CFG_CURSOR_TOP]));
            cw = int'(regs[CFG_CURSOR_WIDTH]);
            ch = int'(regs[CFG_CURSOR_HEIGHT]);
            if (cw > CURSOR_MAX_SIDE_DEF)
                cw = CURSOR_MAX_SIDE_DEF;
            if (ch > CURSOR_MAX_SIDE_DEF)
                ch = CURSOR_MAX_SIDE_DEF;
            if (!regs[CFG_CURSOR_ENABLE][0])
                return -1;
            if (x >= cx && x < cx + cw && y >= cy && y < cy + ch)
                return (y - cy) * cw + (x - cx);
            return -1;
        endfunction

        function void note_request(in_item_t r);
            int         a;
            int         w;
            logic [7:0] v;
            out_item_t  want;
            case (r.mode)
                MODE_GAME_PAL:   game_pal[r.pixel_index] = r.palette_color;
                MODE_CURSOR_PAL: cursor_pal[r.pixel_index] = r.palette_color;
                MODE_CURSOR_IMG:
                begin
                    cursor_img[r.cursor_address] = r.cursor_value;
                    img_written[r.cursor_address] = 1'b1;
                end
                MODE_PIXEL:
                begin
                    a = cursor_offset(r.start_of_frame);
                    if (r.start_of_frame)
                    begin
                        col = 0;
                        row = 0;
                    end
                    want.rgb_out = game_pal[r.pixel_index];
                    if (a >= 0)
                    begin
                        v = cursor_img[a];
                        if (v != regs[CFG_KEY_COLOR][7:0])
                            want.rgb_out = regs[CFG_CURSOR_PAL_SEL][0] ? cursor_pal[v]
                                                                        : game_pal[v];
                    end
                    w = int'(regs[CFG_SCREEN_WIDTH]);
                    if (w == 0)
                        w = 1;
                    if (w > MAX_LINE_WIDTH_DEF)
                        w = MAX_LINE_WIDTH_DEF;
                    want.end_of_line = (col + 1 >= w);
                    want.send_twice = (row % REPEAT_PERIOD_DEF == 0);
                    pixels_due.push_back(want);
                    if (want.end_of_line)
                    begin
                        col = 0;
                        row = (row + 1) % (1 << ROW_W);
                    end
                    else
                        col++;
                end
            endcase
        endfunction

        function void report(string what, out_item_t want, out_item_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("%s: expected rgb %h eol %b twice %b, got rgb %h eol %b twice %b",
                         what, want.rgb_out, want.end_of_line, want.send_twice,
                         got.rgb_out, got.end_of_line, got.send_twice);
        endfunction

        function void check_pixel(out_item_t got);
            out_item_t want;
            if (pixels_due.size() == 0)
            begin
                report("pixel with nothing due", '0, got);
                return;
            end
            want = pixels_due.pop_front();
            if (got.rgb_out !== want.rgb_out || got.end_of_line !== want.end_of_line
                || got.send_twice !== want.send_twice)
                report("pixel mismatch", want, got);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    overlay_scoreboard     sb;
    logic [CFG_DATA_W-1:0] cfg_vals [REG_COUNT];
    bit                    tx_idle  = 1'b0;
    bit                    rx_idle  = 1'b0;
    bit                    hold_req = 1'b0;

    palette_pixel_with_cursor_overlay i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && in_valid === 1'b1 && in_stall === 1'b0)
            sb.note_request(in_data);
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_pixel(out_data);
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic in_item_t request(mode_t m, bit sof, logic [7:0] idx,
                                         logic [15:0] colour, logic [11:0] addr,
                                         logic [7:0] val);
        in_item_t r;
        r.mode = m;
        r.start_of_frame = sof;
        r.pixel_index = idx;
        r.palette_color = colour;
        r.cursor_address = addr;
        r.cursor_value = val;
        return r;
    endfunction

    // pixels and cursor values stay in the low and high bands of the palettes
    function automatic logic [7:0] pick_index();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, USED_BAND - 1));
        return 8'($urandom_range(PALETTE_ENTRIES_DEF - USED_BAND, PALETTE_ENTRIES_DEF - 1));
    endfunction

    function automatic in_item_t random_request(mode_t m);
        return request(m, $urandom_range(0, 19) == 0, pick_index(), 16'($urandom),
                       12'($urandom), pick_index());
    endfunction

    function automatic mode_t random_mode();
        int p = $urandom_range(0, 9);
        if (p < 7)
            return MODE_PIXEL;
        if (p == 7)
            return MODE_GAME_PAL;
        if (p == 8)
            return MODE_CURSOR_PAL;
        return MODE_CURSOR_IMG;
    endfunction

    function automatic void pick_settings(int ph);
        cfg_vals[CFG_SCREEN_WIDTH]   = CFG_DATA_W'(($urandom_range(0, 5) == 0)
                                                   ? $urandom_range(17, 80)
                                                   : $urandom_range(2, 12));
        cfg_vals[CFG_CURSOR_LEFT]    = CFG_DATA_W'($urandom_range(0, 20) - 6);
        cfg_vals[CFG_CURSOR_TOP]     = CFG_DATA_W'($urandom_range(0, 12) - 4);
        cfg_vals[CFG_CURSOR_WIDTH]   = CFG_DATA_W'($urandom_range(1, 8));
        cfg_vals[CFG_CURSOR_HEIGHT]  = CFG_DATA_W'($urandom_range(1, 8));
        cfg_vals[CFG_KEY_COLOR]      = CFG_DATA_W'($urandom_range(0, 255));
        cfg_vals[CFG_CURSOR_ENABLE]  = CFG_DATA_W'($urandom_range(0, 5) != 0);
        cfg_vals[CFG_CURSOR_PAL_SEL] = CFG_DATA_W'($urandom_range(0, 1));
        case (ph)
            0:
            begin
                cfg_vals[CFG_SCREEN_WIDTH]   = 11'd0;
                cfg_vals[CFG_CURSOR_LEFT]    = CFG_DATA_W'(-1024);
                cfg_vals[CFG_CURSOR_TOP]     = CFG_DATA_W'(-1024);
                cfg_vals[CFG_CURSOR_WIDTH]   = 11'd127;
                cfg_vals[CFG_CURSOR_HEIGHT]  = 11'd127;
                cfg_vals[CFG_KEY_COLOR]      = 11'd0;
                cfg_vals[CFG_CURSOR_ENABLE]  = 11'd1;
                cfg_vals[CFG_CURSOR_PAL_SEL] = 11'd0;
            end
            1:
            begin
                cfg_vals[CFG_SCREEN_WIDTH]   = 11'd2047;
                cfg_vals[CFG_CURSOR_LEFT]    = 11'd1023;
                cfg_vals[CFG_CURSOR_TOP]     = 11'd1023;
                cfg_vals[CFG_CURSOR_WIDTH]   = 11'd64;
                cfg_vals[CFG_CURSOR_HEIGHT]  = 11'd64;
                cfg_vals[CFG_KEY_COLOR]      = 11'd255;
                cfg_vals[CFG_CURSOR_ENABLE]  = 11'd1;
                cfg_vals[CFG_CURSOR_PAL_SEL] = 11'd1;
            end
            2:
            begin
                // empty cursor: no width
                cfg_vals[CFG_SCREEN_WIDTH]  = 11'd1024;
                cfg_vals[CFG_CURSOR_LEFT]   = 11'd0;
                cfg_vals[CFG_CURSOR_TOP]    = 11'd0;
                cfg_vals[CFG_CURSOR_WIDTH]  = 11'd0;
                cfg_vals[CFG_CURSOR_HEIGHT] = 11'd64;
                cfg_vals[CFG_CURSOR_ENABLE] = 11'd1;
            end
            3:
            begin
                // empty cursor: no height
                cfg_vals[CFG_SCREEN_WIDTH]  = 11'd1;
                cfg_vals[CFG_CURSOR_LEFT]   = 11'd0;
                cfg_vals[CFG_CURSOR_TOP]    = 11'd0;
                cfg_vals[CFG_CURSOR_WIDTH]  = 11'd64;
                cfg_vals[CFG_CURSOR_HEIGHT] = 11'd0;
                cfg_vals[CFG_CURSOR_ENABLE] = 11'd1;
            end
            4:
            begin
                // full-size cursor hanging over the top left corner
                cfg_vals[CFG_SCREEN_WIDTH]  = 11'd6;
                cfg_vals[CFG_CURSOR_LEFT]   = CFG_DATA_W'(-2);
                cfg_vals[CFG_CURSOR_TOP]    = CFG_DATA_W'(-3);
                cfg_vals[CFG_CURSOR_WIDTH]  = 11'd64;
                cfg_vals[CFG_CURSOR_HEIGHT] = 11'd64;
                cfg_vals[CFG_CURSOR_ENABLE] = 11'd1;
            end
            5:
                cfg_vals[CFG_CURSOR_ENABLE] = 11'd0;
            6:
            begin
                cfg_vals[CFG_SCREEN_WIDTH]  = 11'd2;
                cfg_vals[CFG_CURSOR_LEFT]   = CFG_DATA_W'(-1);
                cfg_vals[CFG_CURSOR_TOP]    = 11'd0;
                cfg_vals[CFG_CURSOR_WIDTH]  = 11'd3;
                cfg_vals[CFG_CURSOR_HEIGHT] = 11'd127;
                cfg_vals[CFG_CURSOR_ENABLE] = 11'd1;
            end
            default: ;
        endcase
        // junk in the unused upper bits of the narrow registers
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_vals[CFG_CURSOR_WIDTH][10:7]   = 4'($urandom);
            cfg_vals[CFG_CURSOR_HEIGHT][10:7]  = 4'($urandom);
            cfg_vals[CFG_KEY_COLOR][10:8]      = 3'($urandom);
            cfg_vals[CFG_CURSOR_ENABLE][10:1]  = 10'($urandom);
            cfg_vals[CFG_CURSOR_PAL_SEL][10:1] = 10'($urandom);
        end
    endfunction

    task automatic program_regs();
        for (int i = 0; i < REG_COUNT; i++)
        begin
            cfg_index <= cfg_index_t'(i);
            cfg_data <= cfg_vals[i];
            cfg_we <= 1'b1;
            @(posedge clk);
            sb.set_reg(cfg_index_t'(i), cfg_vals[i]);
            @(negedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    task automatic push(in_item_t r);
        if (tx_idle && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_data <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // a pixel over the cursor must never read an image entry that was never written
    task automatic send(in_item_t r);
        in_item_t fill;
        int       a;
        if (r.mode == MODE_PIXEL)
        begin
            a = sb.cursor_offset(r.start_of_frame);
            if (a >= 0 && !sb.img_written[a])
            begin
                fill = random_request(MODE_CURSOR_IMG);
                fill.cursor_address = 12'(a);
                if ($urandom_range(0, 3) == 0)
                    fill.cursor_value = sb.regs[CFG_KEY_COLOR][7:0];
                push(fill);
            end
        end
        push(r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pixels_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic directed_run();
        cfg_vals[CFG_SCREEN_WIDTH]   = 11'd4;
        cfg_vals[CFG_CURSOR_LEFT]    = 11'd1;
        cfg_vals[CFG_CURSOR_TOP]     = 11'd1;
        cfg_vals[CFG_CURSOR_WIDTH]   = 11'd2;
        cfg_vals[CFG_CURSOR_HEIGHT]  = 11'd2;
        cfg_vals[CFG_KEY_COLOR]      = 11'hA5;
        cfg_vals[CFG_CURSOR_ENABLE]  = 11'd1;
        cfg_vals[CFG_CURSOR_PAL_SEL] = 11'd1;
        program_regs();
        send(request(MODE_CURSOR_IMG, 1'b0, 8'd0, 16'h0000, 12'd0, 8'hA5));
        send(request(MODE_CURSOR_IMG, 1'b1, 8'd0, 16'h0000, 12'd1, 8'h00));
        send(request(MODE_CURSOR_IMG, 1'b0, 8'd0, 16'h0000, 12'd2, 8'hFF));
        send(request(MODE_CURSOR_IMG, 1'b0, 8'd0, 16'h0000, 12'd3, 8'h07));
        // palette write straight followed by a pixel reading that entry
        send(request(MODE_GAME_PAL, 1'b1, 8'd3, 16'h1234, 12'hFFF, 8'hFF));
        send(request(MODE_PIXEL, 1'b1, 8'd3, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'hFF, 16'hFFFF, 12'hFFF, 8'hFF));
        send(request(MODE_PIXEL, 1'b0, 8'h00, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd3, 16'h0000, 12'd0, 8'h00));
        // second row crosses the cursor: key colour, then cursor palette entry 0
        send(request(MODE_PIXEL, 1'b0, 8'd1, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd2, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd3, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd4, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_CURSOR_PAL, 1'b0, 8'hFF, 16'hBEEF, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd5, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd6, 16'h0000, 12'd0, 8'h00));
        // image write straight followed by a pixel reading that entry
        send(request(MODE_CURSOR_IMG, 1'b0, 8'd0, 16'h0000, 12'd3, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd7, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd8, 16'h0000, 12'd0, 8'h00));
        // start of frame in the middle of a line
        send(request(MODE_PIXEL, 1'b0, 8'd9, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b1, 8'd10, 16'h0000, 12'd0, 8'h00));
        send(request(MODE_PIXEL, 1'b0, 8'd11, 16'h0000, 12'd0, 8'h00));
        drain();
    endtask

    initial
    begin
        in_item_t r;
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        tx_idle = 1'b1;
        rx_idle = 1'b1;
        pick_settings(-1);
        program_regs();
        // every palette entry in the used bands gets a colour before any pixel is sent
        for (int i = 0; i < USED_BAND; i++)
        begin
            r = random_request(MODE_GAME_PAL);
            r.pixel_index = 8'(i);
            send(r);
            r = random_request(MODE_GAME_PAL);
            r.pixel_index = 8'(PALETTE_ENTRIES_DEF - USED_BAND + i);
            send(r);
            r = random_request(MODE_CURSOR_PAL);
            r.pixel_index = 8'(i);
            send(r);
            r = random_request(MODE_CURSOR_PAL);
            r.pixel_index = 8'(PALETTE_ENTRIES_DEF - USED_BAND + i);
            send(r);
        end
        drain();

        directed_run();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            pick_settings(ph);
            program_regs();
            tx_idle = ($urandom_range(0, 2) != 0);
            rx_idle = ($urandom_range(0, 2) != 0);
            if (ph == HOLD_PHASE)
            begin
                tx_idle = 1'b0;
                hold_req = 1'b1;
            end
            if (ph == PHASES - 1)
            begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end
            repeat (PHASE_ITEMS)
                send(random_request(random_mode()));
            drain();
        end

        if (sb.mismatches == 0 && sb.pixels_due.size() == 0)
            $display("palette_pixel_with_cursor_overlay regression: pass");
        else
            $display("palette_pixel_with_cursor_overlay regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("palette_pixel_with_cursor_overlay regression: fail");
        $finish;
    end

endmodule
